### rtl/wbrm_pkg.sv
// Shared types and constants for the write-behind memory window.
`default_nettype none
package wbrm_pkg;

  // Page geometry
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_AW    = 12;
  localparam int COPY_CW    = 13;

  // Request types
  localparam logic [2:0] RT_WIN_RD = 3'd0;
  localparam logic [2:0] RT_WIN_WR = 3'd1;
  localparam logic [2:0] RT_CTL_RD = 3'd2;
  localparam logic [2:0] RT_CTL_WR = 3'd3;
  localparam logic [2:0] RT_TICK   = 3'd4;

  // Control register offsets
  localparam logic [15:0] OFF_MAGIC   = 16'h0000;
  localparam logic [15:0] OFF_DELAY   = 16'h0004;
  localparam logic [15:0] OFF_CTRL    = 16'h000c;
  localparam logic [15:0] OFF_RDCNT   = 16'h0010;
  localparam logic [15:0] OFF_WRCNT   = 16'h0014;
  localparam logic [15:0] OFF_CMCNT   = 16'h0018;
  localparam logic [15:0] OFF_PENDING = 16'h001c;
  localparam logic [15:0] OFF_IRQ     = 16'h0020;
  localparam logic [15:0] OFF_LATENCY = 16'h0024;

  // Control bits
  localparam logic [31:0] CTL_BYPASS   = 32'h1;
  localparam logic [31:0] CTL_WT       = 32'h2;
  localparam logic [31:0] CTL_IRQ      = 32'h4;
  localparam logic [31:0] CTL_COHERENT = 32'h10;

  localparam logic [31:0] MAGIC_WORD  = 32'h4e544f33;
  localparam logic [31:0] DELAY_RESET = 32'd1000000;

  // Sequencer states
  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_RD_END = 10'b0000001000,
    S_WR     = 10'b0000010000,
    S_SCAN   = 10'b0000100000,
    S_CHK    = 10'b0001000000,
    S_COPY   = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

endpackage
`default_nettype wire

### rtl/wbrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wbrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/write_behind_remote_memory_unit.sv
// Top level: write-behind memory window with latest and committed copies.
`default_nettype none
// A request is taken when start is high and busy is low; its result shows on
// rdata/irq_level for one cycle with done high, and must be taken then since
// the receiver cannot stall. done rises in the first cycle that busy is low
// again. The byte RAMs have one port each way, so a window read steps through
// the bytes in S_RD and then S_RD_END, and a window write through the bytes
// in S_WR; an access out of window or of odd size goes straight to S_DONE, as
// does a control access or an unknown type, but setting write-through or
// coherent runs a page flush. A tick or a flush scans every page, checks each
// pending page in S_CHK and copies each page committed, one byte per cycle
// through the copy path, then finishes through S_FIN.
// After reset a clearing pass zeroes all WINDOW_PAGES*4096 bytes of both
// copies; busy stays high meanwhile.
module write_behind_remote_memory_unit #(
  parameter int WINDOW_PAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] addr,
  input  wire logic [63:0] wdata,
  input  wire logic [3:0]  access_bytes,
  // result channel
  output logic             done,
  output logic      [63:0] rdata,
  output logic             irq_level,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int WIN_BYTES = WINDOW_PAGES * wbrm_pkg::PAGE_BYTES;
  localparam int WA        = $clog2(WIN_BYTES);
  localparam int PIW       = (WINDOW_PAGES > 1) ? $clog2(WINDOW_PAGES) : 1;
  localparam int PTW       = $clog2(WINDOW_PAGES + 1);

  wbrm_pkg::state_t state;

  // architectural state
  logic                    coherent_strap;
  logic [WINDOW_PAGES-1:0] pending;
  logic [63:0]             time_now;
  logic [31:0]             commit_delay;
  logic [31:0]             control_bits;
  logic [31:0]             read_count;
  logic [31:0]             write_count;
  logic [31:0]             commit_count;
  logic [PTW-1:0]          pending_total;
  logic [31:0]             last_latency;
  logic                    irq_flag;

  // sequencer working registers
  logic [WA-1:0]                    clr_cnt;
  logic [WA-1:0]                    base_q;
  logic [3:0]                       size_q;
  logic [3:0]                       bi;
  logic [2:0]                       lane_q;
  logic                             rv;
  logic                             sel_latest;
  logic                             wt_q;
  logic [63:0]                      wd_q;
  logic [63:0]                      acc;
  logic [PIW-1:0]                   sp;
  logic                             flush_q;
  logic                             hit_any;
  logic [wbrm_pkg::COPY_CW-1:0]     cnt;

  // RAM ports
  logic          l_we, c_we;
  logic [WA-1:0] l_waddr, c_waddr, l_raddr, c_raddr;
  logic [7:0]    l_wdata, c_wdata, l_rdata, c_rdata;
  logic          m_we;
  logic [127:0]  m_wdata, m_rdata;

  // request decode
  logic           accept;
  logic [31:0]    acc_end;
  logic           acc_ok;
  logic [PIW-1:0] pg;
  logic           wt_mode;
  logic           arm;
  logic [WA-1:0]  byte_addr;
  logic [wbrm_pkg::COPY_CW-1:0] cnt_m1;
  logic [63:0]    deadline, armed_time;
  logic           hit;
  logic           last_page;
  logic [31:0]    ctl_rd;

  assign busy    = (state != wbrm_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign acc_end = 32'(addr) + 32'(access_bytes);
  assign acc_ok  = (access_bytes >= 4'd1) && (access_bytes <= 4'd8) &&
                   (acc_end <= 32'(WIN_BYTES));
  assign pg      = PIW'(addr >> wbrm_pkg::PAGE_AW);
  assign wt_mode = ((control_bits & wbrm_pkg::CTL_WT) != 32'd0) || coherent_strap;
  assign arm     = accept && (req_type == wbrm_pkg::RT_WIN_WR) && acc_ok &&
                   !wt_mode && !pending[pg];
  assign byte_addr  = base_q + WA'(bi);
  assign cnt_m1     = cnt - wbrm_pkg::COPY_CW'(1);
  assign deadline   = m_rdata[63:0];
  assign armed_time = m_rdata[127:64];
  assign hit        = flush_q || (deadline <= time_now);
  assign last_page  = (sp == PIW'(WINDOW_PAGES - 1));

  // control register read mux
  always_comb begin
    case (addr)
      wbrm_pkg::OFF_MAGIC:   ctl_rd = wbrm_pkg::MAGIC_WORD;
      wbrm_pkg::OFF_DELAY:   ctl_rd = commit_delay;
      wbrm_pkg::OFF_CTRL:    ctl_rd = control_bits;
      wbrm_pkg::OFF_RDCNT:   ctl_rd = read_count;
      wbrm_pkg::OFF_WRCNT:   ctl_rd = write_count;
      wbrm_pkg::OFF_CMCNT:   ctl_rd = commit_count;
      wbrm_pkg::OFF_PENDING: ctl_rd = 32'(pending_total);
      wbrm_pkg::OFF_IRQ:     ctl_rd = {31'd0, irq_flag};
      wbrm_pkg::OFF_LATENCY: ctl_rd = last_latency;
      default:               ctl_rd = 32'd0;
    endcase
  end

  // byte RAM port steering
  always_comb begin
    l_we    = 1'b0;
    l_waddr = byte_addr;
    l_wdata = wd_q[7:0];
    c_we    = 1'b0;
    c_waddr = byte_addr;
    c_wdata = wd_q[7:0];
    l_raddr = byte_addr;
    c_raddr = byte_addr;
    case (state)
      wbrm_pkg::S_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_cnt;
        l_wdata = 8'd0;
        c_we    = 1'b1;
        c_waddr = clr_cnt;
        c_wdata = 8'd0;
      end
      wbrm_pkg::S_WR: begin
        l_we = 1'b1;
        c_we = wt_q;
      end
      wbrm_pkg::S_COPY: begin
        l_raddr = WA'({sp, cnt[wbrm_pkg::PAGE_AW-1:0]});
        c_we    = (cnt != '0);
        c_waddr = WA'({sp, cnt_m1[wbrm_pkg::PAGE_AW-1:0]});
        c_wdata = l_rdata;
      end
      default: begin
      end
    endcase
  end

  assign m_we    = arm;
  assign m_wdata = {time_now, time_now + 64'(commit_delay)};

  wbrm_ram #(.WIDTH(8), .DEPTH(WIN_BYTES), .AW(WA)) u_latest (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  wbrm_ram #(.WIDTH(8), .DEPTH(WIN_BYTES), .AW(WA)) u_committed (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // per-page deadline and arm time
  wbrm_ram #(.WIDTH(128), .DEPTH(WINDOW_PAGES), .AW(PIW)) u_meta (
    .clk(clk), .we(m_we), .waddr(pg), .wdata(m_wdata),
    .raddr(sp), .rdata(m_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {31'd0, coherent_strap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coherent_strap <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == 1'b0)) begin
      coherent_strap <= pwdata[0];
    end
  end

  // read byte capture
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= (state == wbrm_pkg::S_RD);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wbrm_pkg::S_CLEAR;
      clr_cnt       <= '0;
      pending       <= '0;
      time_now      <= 64'd0;
      commit_delay  <= wbrm_pkg::DELAY_RESET;
      control_bits  <= 32'd0;
      read_count    <= 32'd0;
      write_count   <= 32'd0;
      commit_count  <= 32'd0;
      pending_total <= '0;
      last_latency  <= 32'd0;
      irq_flag      <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= (state == wbrm_pkg::S_DONE);
      if (rv) begin
        acc[lane_q*8 +: 8] <= sel_latest ? l_rdata : c_rdata;
      end
      case (state)
        wbrm_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + WA'(1);
          if (clr_cnt == WA'(WIN_BYTES - 1)) begin
            state <= wbrm_pkg::S_IDLE;
          end
        end
        wbrm_pkg::S_IDLE: begin
          if (start) begin
            acc    <= 64'd0;
            base_q <= WA'(addr);
            size_q <= access_bytes;
            bi     <= 4'd0;
            wd_q   <= wdata;
            wt_q   <= wt_mode;
            sp     <= '0;
            hit_any <= 1'b0;
            flush_q <= 1'b0;
            sel_latest <= ((control_bits & (wbrm_pkg::CTL_BYPASS |
                           wbrm_pkg::CTL_COHERENT)) != 32'd0) || coherent_strap;
            state  <= wbrm_pkg::S_DONE;
            case (req_type)
              wbrm_pkg::RT_WIN_RD: begin
                read_count <= read_count + 32'd1;
                if (acc_ok) begin
                  state <= wbrm_pkg::S_RD;
                end
              end
              wbrm_pkg::RT_WIN_WR: begin
                write_count <= write_count + 32'd1;
                if (acc_ok) begin
                  state <= wbrm_pkg::S_WR;
                end
                if (arm) begin
                  pending[pg]   <= 1'b1;
                  pending_total <= pending_total + PTW'(1);
                end
              end
              wbrm_pkg::RT_CTL_RD: begin
                acc <= {32'd0, ctl_rd};
              end
              wbrm_pkg::RT_CTL_WR: begin
                case (addr)
                  wbrm_pkg::OFF_DELAY: commit_delay <= wdata[31:0];
                  wbrm_pkg::OFF_CTRL: begin
                    control_bits <= wdata[31:0];
                    if ((wdata[31:0] & (wbrm_pkg::CTL_WT | wbrm_pkg::CTL_COHERENT))
                        != 32'd0) begin
                      flush_q <= 1'b1;
                      state   <= wbrm_pkg::S_SCAN;
                    end
                  end
                  wbrm_pkg::OFF_IRQ: irq_flag <= 1'b0;
                  default: begin
                  end
                endcase
              end
              wbrm_pkg::RT_TICK: begin
                time_now <= time_now + 64'd1;
                state    <= wbrm_pkg::S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        wbrm_pkg::S_RD: begin
          lane_q <= bi[2:0];
          bi     <= bi + 4'd1;
          if (bi == size_q - 4'd1) begin
            state <= wbrm_pkg::S_RD_END;
          end
        end
        wbrm_pkg::S_RD_END: begin
          state <= wbrm_pkg::S_DONE;
        end
        wbrm_pkg::S_WR: begin
          wd_q <= wd_q >> 8;
          bi   <= bi + 4'd1;
          if (bi == size_q - 4'd1) begin
            state <= wbrm_pkg::S_DONE;
          end
        end
        wbrm_pkg::S_SCAN: begin
          if (pending[sp]) begin
            state <= wbrm_pkg::S_CHK;
          end else if (last_page) begin
            state <= wbrm_pkg::S_FIN;
          end else begin
            sp <= sp + PIW'(1);
          end
        end
        wbrm_pkg::S_CHK: begin
          if (hit) begin
            pending[sp]  <= 1'b0;
            commit_count <= commit_count + 32'd1;
            cnt          <= '0;
            state        <= wbrm_pkg::S_COPY;
            if (!flush_q) begin
              hit_any      <= 1'b1;
              last_latency <= time_now[31:0] - armed_time[31:0];
              if (pending_total != '0) begin
                pending_total <= pending_total - PTW'(1);
              end
            end
          end else if (last_page) begin
            state <= wbrm_pkg::S_FIN;
          end else begin
            sp    <= sp + PIW'(1);
            state <= wbrm_pkg::S_SCAN;
          end
        end
        wbrm_pkg::S_COPY: begin
          cnt <= cnt + wbrm_pkg::COPY_CW'(1);
          if (cnt == wbrm_pkg::COPY_CW'(wbrm_pkg::PAGE_BYTES)) begin
            if (last_page) begin
              state <= wbrm_pkg::S_FIN;
            end else begin
              sp    <= sp + PIW'(1);
              state <= wbrm_pkg::S_SCAN;
            end
          end
        end
        wbrm_pkg::S_FIN: begin
          if (flush_q) begin
            pending_total <= '0;
          end else if (hit_any && ((control_bits & wbrm_pkg::CTL_IRQ) != 32'd0)) begin
            irq_flag <= 1'b1;
          end
          state <= wbrm_pkg::S_DONE;
        end
        wbrm_pkg::S_DONE: begin
          state <= wbrm_pkg::S_IDLE;
        end
        default: begin
          state <= wbrm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == wbrm_pkg::S_DONE) begin
      rdata     <= acc;
      irq_level <= irq_flag;
    end
  end

  // pending count tracks the pending bits whenever the sequencer rests
  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    (state == wbrm_pkg::S_IDLE) |-> (32'(pending_total) == $countones(pending)))
    else $error("pending count out of step with pending pages");

  // committed copy is only written while busy
  a_cwe_busy: assert property (@(posedge clk) disable iff (rst)
    c_we |-> busy)
    else $error("committed copy written while idle");

  // a result strobe follows every completed request
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == wbrm_pkg::S_DONE) |=> (done && (state == wbrm_pkg::S_IDLE)))
    else $error("missing result strobe");

  // page arming only on a clean page outside write-through
  a_arm: assert property (@(posedge clk) disable iff (rst)
    arm |=> pending[$past(pg)])
    else $error("page not armed");

endmodule
`default_nettype wire

### sim/wbrm_checker.sv
// Scoreboard for the write-behind memory window: mirrors its state and checks every result.
module wbrm_checker
  import wbrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] addr,
  input  wire logic [63:0] wdata,
  input  wire logic [3:0]  access_bytes,
  input  wire logic        done,
  input  wire logic [63:0] rdata,
  input  wire logic        irq_level,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors,
  output int               outstanding
);

  localparam int NPAGES = 16;
  localparam int WIN    = NPAGES * PAGE_BYTES;

  typedef struct packed {
    logic [63:0] rdata;
    logic        irq;
  } answer_t;

  answer_t     answers_due[$];

  // mirrored block state
  logic [7:0]  latest_mem [WIN];
  logic [7:0]  commit_mem [WIN];
  logic        pend   [NPAGES];
  logic [63:0] dline  [NPAGES];
  logic [63:0] armed  [NPAGES];
  logic [63:0] now_ns;
  logic [31:0] delay_r, ctl_r, rd_cnt, wr_cnt, cm_cnt, pend_tot, last_lat;
  logic        irq_r, strap_r;

  function automatic bit size_ok(logic [15:0] a, logic [3:0] sz);
    return sz >= 1 && sz <= 8 && (32'(a) + 32'(sz)) <= WIN;
  endfunction

  function void commit_page(int p);
    for (int i = 0; i < PAGE_BYTES; i++)
      commit_mem[p*PAGE_BYTES + i] = latest_mem[p*PAGE_BYTES + i];
    pend[p]  = 1'b0;
    dline[p] = '0;
  endfunction

  // one request in, expected answer out
  function answer_t predict_answer(logic [2:0] rt, logic [15:0] a, logic [63:0] d,
                                   logic [3:0] sz);
    answer_t ans;
    int      n;
    int      p;
    ans = '0;
    case (rt)
      RT_WIN_RD: begin
        rd_cnt++;
        if (size_ok(a, sz)) begin
          for (int i = 0; i < sz; i++)
            ans.rdata[8*i +: 8] = ((ctl_r & (CTL_BYPASS | CTL_COHERENT)) != 0 || strap_r) ?
                                  latest_mem[a + i] : commit_mem[a + i];
        end
      end
      RT_WIN_WR: begin
        wr_cnt++;
        if (size_ok(a, sz)) begin
          for (int i = 0; i < sz; i++) latest_mem[a + i] = d[8*i +: 8];
          if ((ctl_r & CTL_WT) != 0 || strap_r) begin
            for (int i = 0; i < sz; i++) commit_mem[a + i] = d[8*i +: 8];
          end else begin
            p = a / PAGE_BYTES;
            if (!pend[p]) begin
              pend[p]  = 1'b1;
              pend_tot++;
              armed[p] = now_ns;
              dline[p] = now_ns + 64'(delay_r);
            end
          end
        end
      end
      RT_CTL_RD: begin
        case (a)
          OFF_MAGIC:   ans.rdata = 64'(MAGIC_WORD);
          OFF_DELAY:   ans.rdata = 64'(delay_r);
          OFF_CTRL:    ans.rdata = 64'(ctl_r);
          OFF_RDCNT:   ans.rdata = 64'(rd_cnt);
          OFF_WRCNT:   ans.rdata = 64'(wr_cnt);
          OFF_CMCNT:   ans.rdata = 64'(cm_cnt);
          OFF_PENDING: ans.rdata = 64'(pend_tot);
          OFF_IRQ:     ans.rdata = 64'(irq_r);
          OFF_LATENCY: ans.rdata = 64'(last_lat);
          default:     ans.rdata = '0;
        endcase
      end
      RT_CTL_WR: begin
        case (a)
          OFF_DELAY: delay_r = d[31:0];
          OFF_CTRL: begin
            ctl_r = d[31:0];
            // write-through or coherent drains everything, no irq
            if ((ctl_r & (CTL_WT | CTL_COHERENT)) != 0) begin
              for (int q = 0; q < NPAGES; q++)
                if (pend[q]) begin
                  commit_page(q);
                  cm_cnt++;
                end
              pend_tot = '0;
            end
          end
          OFF_IRQ: irq_r = 1'b0;
          default: ;
        endcase
      end
      RT_TICK: begin
        n = 0;
        now_ns++;
        for (int q = 0; q < NPAGES; q++)
          if (pend[q] && dline[q] <= now_ns) begin
            commit_page(q);
            if (pend_tot > 0) pend_tot--;
            last_lat = 32'(now_ns - armed[q]);
            n++;
          end
        if (n > 0) begin
          cm_cnt += n;
          if ((ctl_r & CTL_IRQ) != 0) irq_r = 1'b1;
        end
      end
      default: ;
    endcase
    ans.irq = irq_r;
    return ans;
  endfunction

  assign outstanding = answers_due.size();

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst) begin
      for (int i = 0; i < WIN; i++) begin
        latest_mem[i] = '0;
        commit_mem[i] = '0;
      end
      for (int q = 0; q < NPAGES; q++) begin
        pend[q]  = 1'b0;
        dline[q] = '0;
        armed[q] = '0;
      end
      now_ns   = '0;
      delay_r  = DELAY_RESET;
      ctl_r    = '0;
      rd_cnt   = '0;
      wr_cnt   = '0;
      cm_cnt   = '0;
      pend_tot = '0;
      last_lat = '0;
      irq_r    = 1'b0;
      strap_r  = 1'b0;
      answers_due.delete();
      errors   = 0;
    end else begin
      // results first, then the request taken at this edge
      if (done) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result rdata=%h irq_level=%b", rdata, irq_level);
          errors++;
        end else begin
          exp_a = answers_due.pop_front();
          if (rdata !== exp_a.rdata) begin
            $error("rdata expected %h actual %h", exp_a.rdata, rdata);
            errors++;
          end
          if (irq_level !== exp_a.irq) begin
            $error("irq_level expected %b actual %b", exp_a.irq, irq_level);
            errors++;
          end
        end
      end
      if (start && !busy)
        answers_due.push_back(predict_answer(req_type, addr, wdata, access_bytes));
      if (psel && penable && pwrite && pready && paddr == 1'b0)
        strap_r = pwdata[0];
    end
  end

endmodule

### sim/tb_write_behind_remote_memory_unit.sv
// Testbench top: drives requests and strap writes into the memory window and gives the verdict.
module tb_write_behind_remote_memory_unit;
  import wbrm_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [15:0] addr;
  logic [63:0] wdata;
  logic [3:0]  access_bytes;
  logic        done;
  logic [63:0] rdata;
  logic        irq_level;
  logic        psel, penable, pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          errors;
  int          outstanding;
  int          quiet_from;
  int          sent;

  write_behind_remote_memory_unit #(.WINDOW_PAGES(16)) dut (
    .clk, .rst, .start, .busy, .req_type, .addr, .wdata, .access_bytes,
    .done, .rdata, .irq_level,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wbrm_checker chk (
    .clk, .rst, .start, .busy, .req_type, .addr, .wdata, .access_bytes,
    .done, .rdata, .irq_level,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd12 * 64'd400_000_000);
    $display("tb_write_behind_remote_memory_unit failed");
    $finish;
  end

  // one request; start stays high across back-to-back requests
  task automatic send(logic [2:0] rt, logic [15:0] a, logic [63:0] d, logic [3:0] sz);
    start        <= 1'b1;
    req_type     <= rt;
    addr         <= a;
    wdata        <= d;
    access_bytes <= sz;
    // taken at the rising edge after the first falling edge with busy low
    while (busy) @(negedge clk);
    @(negedge clk);
    sent++;
    // random sender gaps, none near the end
    if (sent < quiet_from && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_strap(logic v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 1'b0;
    pwdata  <= {31'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_request();
    int          r;
    logic [15:0] a;
    logic [3:0]  sz;
    logic [31:0] v;
    r  = $urandom_range(0, 99);
    sz = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    case ($urandom_range(0, 19))
      0, 1:    a = 16'($urandom);
      2:       a = 16'hfff0 + 16'($urandom_range(0, 15));
      3:       a = 16'(PAGE_BYTES * $urandom_range(1, 3) - $urandom_range(1, 7));
      default: a = 16'($urandom_range(0, 4 * PAGE_BYTES - 1));
    endcase
    if (r < 30) begin
      send(RT_WIN_WR, a, {$urandom, $urandom}, sz);
    end else if (r < 52) begin
      send(RT_WIN_RD, a, {$urandom, $urandom}, sz);
    end else if (r < 62) begin
      case ($urandom_range(0, 11))
        0:  a = OFF_MAGIC;   1: a = OFF_DELAY;   2: a = OFF_CTRL;
        3:  a = OFF_RDCNT;   4: a = OFF_WRCNT;   5: a = OFF_CMCNT;
        6:  a = OFF_PENDING; 7: a = OFF_IRQ;     8: a = OFF_LATENCY;
        9:  a = 16'h0008;    10: a = 16'h0028;
        default: a = 16'($urandom);
      endcase
      send(RT_CTL_RD, a, {$urandom, $urandom}, sz);
    end else if (r < 70) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          v = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 20));
          send(RT_CTL_WR, OFF_DELAY, {$urandom, v}, sz);
        end
        3, 4, 5: begin
          case ($urandom_range(0, 7))
            0: v = 32'h0;
            1: v = CTL_BYPASS;
            2: v = CTL_WT;
            3: v = CTL_IRQ;
            4: v = CTL_IRQ | CTL_BYPASS;
            5: v = CTL_COHERENT;
            6: v = $urandom & ~(CTL_WT | CTL_COHERENT);
            default: v = $urandom;
          endcase
          send(RT_CTL_WR, OFF_CTRL, {$urandom, v}, sz);
        end
        6, 7: send(RT_CTL_WR, OFF_IRQ, {$urandom, $urandom}, sz);
        default: send(RT_CTL_WR, 16'($urandom), {$urandom, $urandom}, sz);
      endcase
    end else if (r < 97) begin
      repeat ($urandom_range(1, 12)) send(RT_TICK, 16'($urandom), {$urandom, $urandom}, sz);
    end else begin
      send(3'($urandom_range(5, 7)), a, {$urandom, $urandom}, sz);
    end
  endtask

  initial begin
    logic strap_seq [3];
    strap_seq = '{1'b0, 1'b1, 1'b0};
    rst = 1'b1;
    start = 1'b0; req_type = '0; addr = '0; wdata = '0; access_bytes = 4'd1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sent = 0;
    quiet_from = 1000;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_strap(1'b0);

    // directed: registers, extremes, odd sizes, page edge, flush, irq
    send(RT_CTL_RD, OFF_MAGIC, '0, 4'd4);
    send(RT_CTL_RD, OFF_DELAY, '0, 4'd4);
    send(RT_CTL_WR, OFF_DELAY, 64'hffff_ffff_0000_0003, 4'd4);
    send(RT_CTL_WR, OFF_CTRL, {32'h0, CTL_IRQ}, 4'd4);
    send(RT_WIN_WR, 16'h0000, 64'hffff_ffff_ffff_ffff, 4'd8);
    send(RT_WIN_WR, 16'h0ffe, 64'h1122_3344_5566_7788, 4'd4);
    send(RT_WIN_RD, 16'h0000, '0, 4'd8);
    send(RT_WIN_WR, 16'hfffc, 64'haaaa_aaaa_aaaa_aaaa, 4'd8);
    send(RT_WIN_WR, 16'hfff8, 64'h0123_4567_89ab_cdef, 4'd8);
    send(RT_WIN_RD, 16'hffff, '0, 4'd0);
    send(RT_WIN_RD, 16'h0010, '0, 4'd15);
    repeat (4) send(RT_TICK, '0, '0, 4'd1);
    send(RT_WIN_RD, 16'h0ffe, '0, 4'd4);
    send(RT_CTL_RD, OFF_LATENCY, '0, 4'd4);
    send(RT_CTL_RD, OFF_IRQ, '0, 4'd4);
    send(RT_CTL_WR, OFF_IRQ, '0, 4'd4);
    send(RT_CTL_RD, 16'h0008, '0, 4'd4);
    send(RT_CTL_WR, 16'h0008, 64'h5, 4'd4);
    send(RT_WIN_WR, 16'h2000, 64'h77, 4'd1);
    send(RT_CTL_WR, OFF_CTRL, {32'h0, CTL_WT}, 4'd4);
    send(RT_CTL_RD, OFF_CMCNT, '0, 4'd4);
    send(RT_CTL_RD, OFF_PENDING, '0, 4'd4);
    send(RT_CTL_WR, OFF_CTRL, {32'h0, CTL_BYPASS}, 4'd4);
    send(3'd7, 16'hffff, '1, 4'd8);

    // three phases with strap settings 0, 1 and 0
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      write_strap(strap_seq[ph]);
      if (ph == 2) quiet_from = sent + 200;
      for (int k = 0; k < 140; k++) begin
        random_request();
        if (k == 70) drain();
      end
    end
    drain();
    write_strap(1'b1);
    for (int k = 0; k < 30; k++) random_request();

    drain();
    if (errors == 0) begin
      $display("tb_write_behind_remote_memory_unit passed");
    end else begin
      $display("tb_write_behind_remote_memory_unit failed");
    end
    $finish;
  end

endmodule
